### src/tlba_pkg.sv
// Shared types, constants and helpers for the text line to block assigner.
package tlba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int INDEX_OUT_BITS = 6;

  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic [AREA_BITS-1:0]      area_t;
  typedef logic [IDX_BITS-1:0]       idx_t;
  typedef logic [CNT_BITS-1:0]       cnt_t;
  typedef logic [INDEX_OUT_BITS-1:0] index_out_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ASSIGNED = 2'd2,
    STAT_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } rect_t;

  // One scored block leaving the scoring pipeline
  typedef struct packed {
    logic  valid;
    logic  center;
    area_t inter;
    area_t area;
    idx_t  idx;
  } cand_t;

  // Clamped extent: zero where hi does not lie above lo
  function automatic coord_t span(coord_t lo, coord_t hi);
    return (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

endpackage

### src/tlba_if.sv
// Valid/ready channel interfaces for requests and results.
interface tlba_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  tlba_pkg::coord_t  x_min;
  tlba_pkg::coord_t  y_min;
  tlba_pkg::coord_t  x_max;
  tlba_pkg::coord_t  y_max;

  modport source (output valid, req_type, x_min, y_min, x_max, y_max, input ready);
  modport sink   (input valid, req_type, x_min, y_min, x_max, y_max, output ready);
endinterface

interface tlba_res_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  tlba_pkg::index_out_t   blk_sel;

  modport source (output valid, status, blk_sel, input ready);
  modport sink   (input valid, status, blk_sel, output ready);
endinterface

### src/tlba_block_mem.sv
// Block rectangle store: one write port, one registered read port.
module tlba_block_mem (
  input  logic            clk,
  input  logic            wr_en,
  input  tlba_pkg::idx_t  wr_addr,
  input  tlba_pkg::rect_t wr_data,
  input  logic            rd_en,
  input  tlba_pkg::idx_t  rd_addr,
  output tlba_pkg::rect_t rd_data
);

  tlba_pkg::rect_t mem [tlba_pkg::MAX_BLOCKS];

  // Write appended block
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/tlba_score.sv
// Two-stage scoring pipeline: clamp and centre test, then area products.
module tlba_score (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tlba_pkg::idx_t  in_idx,
  input  tlba_pkg::rect_t blk,
  input  tlba_pkg::rect_t line,
  output logic            busy,
  output tlba_pkg::cand_t cand
);

  logic [tlba_pkg::COORD_BITS:0] cx2, cy2;
  tlba_pkg::coord_t iw_c, ih_c, bw_c, bh_c;
  logic center_c;

  logic             s1_valid;
  tlba_pkg::idx_t   s1_idx;
  tlba_pkg::coord_t s1_iw, s1_ih, s1_bw, s1_bh;
  logic             s1_center;

  // Clamp the intersection and test whether the block holds the line centre
  always_comb begin
    cx2 = {1'b0, line.x0} + {1'b0, line.x1};
    cy2 = {1'b0, line.y0} + {1'b0, line.y1};
    iw_c = tlba_pkg::span((line.x0 > blk.x0) ? line.x0 : blk.x0,
                          (line.x1 < blk.x1) ? line.x1 : blk.x1);
    ih_c = tlba_pkg::span((line.y0 > blk.y0) ? line.y0 : blk.y0,
                          (line.y1 < blk.y1) ? line.y1 : blk.y1);
    bw_c = tlba_pkg::span(blk.x0, blk.x1);
    bh_c = tlba_pkg::span(blk.y0, blk.y1);
    center_c = (cx2 >= {blk.x0, 1'b0}) && (cx2 <= {blk.x1, 1'b0}) &&
               (cy2 >= {blk.y0, 1'b0}) && (cy2 <= {blk.y1, 1'b0});
  end

  // Stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    s1_idx    <= in_idx;
    s1_iw     <= iw_c;
    s1_ih     <= ih_c;
    s1_bw     <= bw_c;
    s1_bh     <= bh_c;
    s1_center <= center_c;
  end

  // Stage two: intersection and block areas
  always_ff @(posedge clk) begin
    cand.inter  <= tlba_pkg::area_t'(s1_iw) * tlba_pkg::area_t'(s1_ih);
    cand.area   <= tlba_pkg::area_t'(s1_bw) * tlba_pkg::area_t'(s1_bh);
    cand.center <= s1_center;
    cand.idx    <= s1_idx;
    if (rst) begin
      cand.valid <= 1'b0;
    end else begin
      cand.valid <= s1_valid;
    end
  end

  assign busy = s1_valid | cand.valid;

endmodule

### src/tlba_select.sv
// Best-block tracker: qualifies each candidate and keeps the winner.
module tlba_select (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tlba_pkg::cand_t cand,
  input  tlba_pkg::area_t line_area,
  output logic            found,
  output tlba_pkg::idx_t  best_idx
);

  tlba_pkg::area_t best_cov, lead_area, cov;
  logic line_nz, half, qual, better;

  // Qualify and compare against the current best
  always_comb begin
    line_nz = (line_area != '0);
    half    = line_nz && ({cand.inter, 1'b0} >= {1'b0, line_area});
    cov     = line_nz ? cand.inter : '0;
    qual    = half | cand.center;
    better  = !found || (cov > best_cov) ||
              ((cov == best_cov) && (cand.area < lead_area));
  end

  // Found flag
  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
    end else if (cand.valid && qual) begin
      found <= 1'b1;
    end
  end

  // Hold the best candidate
  always_ff @(posedge clk) begin
    if (cand.valid && qual && better) begin
      best_cov  <= cov;
      lead_area <= cand.area;
      best_idx  <= cand.idx;
    end
  end

endmodule

### src/text_line_to_block_assigner.sv
// Top level of the text line to block assigner.
//
//   channel | dir | beat payload
//   req     | in  | req_type, x_min, y_min, x_max, y_max
//   res     | out | status, blk_sel
//
// Clear and append need no scan; the result is loaded as the beat is taken.
// A query walks the stored blocks one per cycle through the single memory read
// port and the scoring pipeline; its result is loaded once the pipeline has
// drained, and no new beat is taken before that result has been loaded.
// rst is synchronous and empties the table; memory contents are not cleared.
// A waiting result is held in the output register; a new beat is taken once
// that register is free or being emptied in the same cycle.
module text_line_to_block_assigner (
  input logic         clk,
  input logic         rst,
  tlba_req_if.sink    req,
  tlba_res_if.source  res
);

  tlba_pkg::fsm_t   state, state_next;
  tlba_pkg::cnt_t   count;
  tlba_pkg::cnt_t   rd_ptr;
  tlba_pkg::rect_t  line;
  tlba_pkg::coord_t line_w, line_h;
  tlba_pkg::area_t  line_area;
  tlba_pkg::rect_t  rd_data;
  tlba_pkg::idx_t   mem_idx;
  tlba_pkg::cand_t  cand;
  tlba_pkg::idx_t   best_idx;
  tlba_pkg::rect_t  in_rect;
  logic mem_valid, busy, found;
  logic res_free, accept, rd_en, wr_en, full, is_query, start, finish_load;

  assign in_rect  = '{x0: req.x_min, y0: req.y_min, x1: req.x_max, y1: req.y_max};
  assign res_free = !res.valid || res.ready;
  assign full     = (count == tlba_pkg::cnt_t'(tlba_pkg::MAX_BLOCKS));
  assign is_query = (req.req_type == tlba_pkg::REQ_QUERY);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tlba_pkg::S_IDLE:   if (accept && is_query) state_next = tlba_pkg::S_SCAN;
      tlba_pkg::S_SCAN:   if (!rd_en) state_next = tlba_pkg::S_DRAIN;
      tlba_pkg::S_DRAIN:  if (!mem_valid && !busy) state_next = tlba_pkg::S_FINISH;
      tlba_pkg::S_FINISH: if (res_free) state_next = tlba_pkg::S_IDLE;
      default:            state_next = tlba_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready   = (state == tlba_pkg::S_IDLE) && res_free;
    accept      = req.valid && req.ready;
    rd_en       = (state == tlba_pkg::S_SCAN) && (rd_ptr < count);
    wr_en       = accept && (req.req_type == tlba_pkg::REQ_APPEND) && !full;
    start       = accept && is_query;
    finish_load = (state == tlba_pkg::S_FINISH) && res_free;
  end

  // State, fill count and scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlba_pkg::S_IDLE;
      count     <= '0;
      rd_ptr    <= '0;
      mem_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mem_valid <= rd_en;
      if (accept && (req.req_type == tlba_pkg::REQ_CLEAR)) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 1'b1;
      end
      if (start) begin
        rd_ptr <= '0;
      end else if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Capture the query line and its area
  always_ff @(posedge clk) begin
    if (start) begin
      line   <= in_rect;
      line_w <= tlba_pkg::span(req.x_min, req.x_max);
      line_h <= tlba_pkg::span(req.y_min, req.y_max);
    end
    line_area <= tlba_pkg::area_t'(line_w) * tlba_pkg::area_t'(line_h);
    mem_idx   <= rd_ptr[tlba_pkg::IDX_BITS-1:0];
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if ((accept && !is_query) || finish_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      res.status  <= (wr_en || (req.req_type != tlba_pkg::REQ_APPEND)) ?
                     tlba_pkg::STAT_DONE : tlba_pkg::STAT_FULL;
      res.blk_sel <= '0;
    end else if (finish_load) begin
      res.status  <= found ? tlba_pkg::STAT_ASSIGNED : tlba_pkg::STAT_NONE;
      res.blk_sel <= found ? tlba_pkg::index_out_t'(best_idx) : '0;
    end
  end

  tlba_block_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[tlba_pkg::IDX_BITS-1:0]),
    .wr_data (in_rect),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[tlba_pkg::IDX_BITS-1:0]),
    .rd_data (rd_data)
  );

  tlba_score u_score (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mem_valid),
    .in_idx   (mem_idx),
    .blk      (rd_data),
    .line     (line),
    .busy     (busy),
    .cand     (cand)
  );

  tlba_select u_select (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cand      (cand),
    .line_area (line_area),
    .found     (found),
    .best_idx  (best_idx)
  );

  // Fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tlba_pkg::cnt_t'(tlba_pkg::MAX_BLOCKS))
    else $error("block count beyond table depth");

  // Scan pointer never passes the block count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tlba_pkg::S_SCAN) |-> (rd_ptr <= count))
    else $error("scan pointer beyond block count");

  // The pipeline is empty once the answer is formed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == tlba_pkg::S_FINISH) |-> (!mem_valid && !busy && !cand.valid))
    else $error("query answered with blocks still in flight");

  // A chosen block lies among the stored ones
  a_best_stored: assert property (@(posedge clk) disable iff (rst)
    (finish_load && found) |-> (tlba_pkg::cnt_t'(best_idx) < count))
    else $error("chosen block index beyond block count");

endmodule
